// ===== rtl/core/rcls_pkg.sv =====
`default_nettype none

package rcls_pkg;

    localparam int W_EDGE   = 14;
    localparam int W_TIME   = 24;
    localparam int W_BUDGET = 20;
    localparam int W_COST   = 48;
    localparam int W_LEVEL  = 3;
    localparam int W_PIX    = 28;
    localparam int W_NUM    = 53;
    localparam int W_SAMPLE = 50;
    localparam int W_WGT    = 29;
    localparam int W_DIG    = 4;
    localparam int N_DIG    = 8;
    localparam int W_LIM    = 48;
    localparam int W_TK     = 34;
    localparam int W_LIMHI  = 32;
    localparam int W_IDX    = 2;
    localparam int W_CFG    = 20;
    localparam int W_IN     = 56;
    localparam int W_OUT    = 56;

    typedef logic [W_IDX-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_BUDGET = 2'd0;
    localparam t_cfg_idx REG_EDGE   = 2'd1;

    localparam logic [W_BUDGET-1:0] BUDGET_RST = 20'd16000;
    localparam logic [W_BUDGET-1:0] BUDGET_MIN = 20'd1000;
    localparam logic [W_EDGE-1:0]   EDGE_RST   = 14'd1600;
    localparam logic [W_COST-1:0]   COST_MAX   = {W_COST{1'b1}};
    localparam logic [9:0]          NS_PER_US  = 10'd1000;
    localparam logic [11:0]         LIM_SCALE  = 12'd3000;
    localparam logic [W_PIX-1:0]    BLEND_DIV  = 28'd10;

endpackage

`default_nettype wire

// ===== rtl/core/rcls_serdiv.sv =====
`default_nettype none

module rcls_serdiv (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rcls_pkg::W_NUM-1:0]  i_num,
    input  wire logic [rcls_pkg::W_PIX-1:0]  i_den,
    output logic                             o_done,
    output logic [rcls_pkg::W_NUM-1:0]       o_quot
);
    import rcls_pkg::*;

    localparam int W_CNT = $clog2(W_NUM + 1);

    logic [W_PIX-1:0] r_rem;
    logic [W_PIX-1:0] r_den;
    logic [W_NUM-1:0] r_q;
    logic [W_CNT-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W_PIX:0]   trial;
    logic [W_PIX:0]   diff;
    logic             ge;

    // one quotient bit per cycle, numerator shifted out of the quotient register
    assign trial = {r_rem, r_q[W_NUM-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_den  <= i_den;
                r_q    <= i_num;
                r_cnt  <= W_CNT'(W_NUM);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[W_PIX-1:0] : trial[W_PIX-1:0];
                r_q   <= {r_q[W_NUM-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == W_CNT'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/rcls_fit_chk.sv =====
`default_nettype none

module rcls_fit_chk (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rcls_pkg::W_COST-1:0] i_avg,
    input  wire logic [rcls_pkg::W_LIM-1:0]  i_lim,
    input  wire logic [rcls_pkg::W_WGT-1:0]  i_wgt,
    output logic                             o_done,
    output logic                             o_fit
);
    import rcls_pkg::*;

    localparam int W_SH   = W_DIG * N_DIG;
    localparam int W_CNT  = $clog2(N_DIG + 1);
    localparam int W_ACC  = W_COST + W_DIG + 1;
    localparam int W_PART = W_COST + W_DIG;

    logic [W_LIM-1:0]         r_acc;
    logic [W_SH-1:0]          r_wsh;
    logic [W_CNT-1:0]         r_cnt;
    logic                     r_busy;
    logic                     r_over;
    logic                     r_done;

    logic [W_COST+W_DIG-1:0]  part;
    logic [W_ACC-1:0]         sum;

    // avg * weight, one 4-bit digit of the weight per cycle, msb first;
    // the running sum only grows, so once past the limit it stays past
    assign part = W_PART'(i_avg) * W_PART'(r_wsh[W_SH-1 -: W_DIG]);
    assign sum  = W_ACC'({r_acc, {W_DIG{1'b0}}}) + W_ACC'(part);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc  <= '0;
                r_wsh  <= W_SH'(i_wgt);
                r_cnt  <= W_CNT'(N_DIG);
                r_over <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_wsh <= {r_wsh[W_SH-W_DIG-1:0], {W_DIG{1'b0}}};
                if (!r_over) begin
                    if (sum > W_ACC'(i_lim)) begin
                        r_over <= 1'b1;
                    end else begin
                        r_acc <= sum[W_LIM-1:0];
                    end
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == W_CNT'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_fit  = !r_over;

endmodule

`default_nettype wire

// ===== rtl/core/render_cost_level_selector.sv =====
`default_nettype none

// Learns the rendering cost in ns per pixel (unsigned Q32.16) from each finished-frame
// report and answers every report with one item: whether the report updated the
// estimate, the estimate itself and the finest preview level predicted to fit the
// budget, or the coarsest level if none fits. Re-decoded frames and reports with a
// zero dimension or zero time leave the estimate alone. An accepted report runs a
// bit-serial divide for the sample and, once there is a nonzero estimate, another
// bit-serial divide by ten for the 0.7/0.3 blend. The level walk tries one level at
// a time (a square, then an 8-digit serial multiply against the budget), finest
// first, up to NUM_LEVELS levels. A new report is taken while the previous result
// still waits on the output.
module render_cost_level_selector #(
    parameter int NUM_LEVELS = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // frame_width, frame_height, frame_time_us, zero pad
    input  wire logic [rcls_pkg::W_IN-1:0]     s_axis_tdata,
    // rehydrated
    input  wire logic                          s_axis_tuser,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // cost_estimate, chosen_level, zero pad
    output logic [rcls_pkg::W_OUT-1:0]         m_axis_tdata,
    // sample_taken
    output logic                               m_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic                          i_cfg_we,
    input  wire rcls_pkg::t_cfg_idx            i_cfg_idx,
    input  wire logic [rcls_pkg::W_CFG-1:0]    i_cfg_data
);
    import rcls_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SDIV_GO, S_SDIV, S_BDIV_GO, S_BDIV,
        S_UPD, S_LSQ, S_LGO, S_LWAIT, S_OUT
    } t_state;

    localparam logic [W_LEVEL-1:0] LAST_LEVEL = W_LEVEL'(NUM_LEVELS - 1);

    t_state              r_state;
    logic [W_BUDGET-1:0] r_budget;
    logic [W_EDGE-1:0]   r_edge;
    logic [W_COST-1:0]   r_avg;

    logic [W_EDGE-1:0]   r_fw;
    logic [W_EDGE-1:0]   r_fh;
    logic [W_TIME-1:0]   r_ft;
    logic                r_ok;
    logic [W_PIX-1:0]    r_pix;
    logic [W_TK-1:0]     r_tk;
    logic [W_NUM-1:0]    r_avg7;
    logic [W_NUM-1:0]    r_s3;
    logic [W_NUM-1:0]    r_next;
    logic [W_LIM-1:0]    r_lim;
    logic [W_WGT-1:0]    r_wgt;
    logic [W_LEVEL-1:0]  r_lvl;
    logic                r_taken;

    logic                r_o_valid;
    logic                r_o_taken;
    logic [W_COST-1:0]   r_o_cost;
    logic [W_LEVEL-1:0]  r_o_level;

    logic                in_acc;
    logic                div_start;
    logic [W_NUM-1:0]    div_num;
    logic [W_PIX-1:0]    div_den;
    logic                div_done;
    logic [W_NUM-1:0]    div_quot;
    logic                chk_start;
    logic                chk_done;
    logic                chk_fit;

    logic [W_BUDGET-1:0] budget_c;
    logic [W_LIMHI-1:0]  lim_hi;
    logic [W_EDGE-1:0]   edge0;
    logic [W_EDGE-1:0]   e_sh;
    logic [W_EDGE-1:0]   e_lvl;
    logic [2*W_EDGE-1:0] e_sq;
    logic [W_COST-1:0]   next_sat;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    assign budget_c = (r_budget < BUDGET_MIN) ? BUDGET_MIN : r_budget;
    assign lim_hi   = W_LIMHI'(budget_c) * W_LIMHI'(LIM_SCALE);
    assign edge0    = (r_edge == '0) ? W_EDGE'(1) : r_edge;
    assign e_sh     = edge0 >> r_lvl;
    assign e_lvl    = (e_sh == '0) ? W_EDGE'(1) : e_sh;
    assign e_sq     = {{W_EDGE{1'b0}}, e_lvl} * {{W_EDGE{1'b0}}, e_lvl};
    assign next_sat = (|r_next[W_NUM-1:W_COST]) ? COST_MAX : r_next[W_COST-1:0];

    assign div_start = (r_state == S_SDIV_GO) || (r_state == S_BDIV_GO);
    assign div_num   = (r_state == S_BDIV_GO) ? (r_avg7 + r_s3)
                                              : W_NUM'({r_tk, 16'h0000});
    assign div_den   = (r_state == S_BDIV_GO) ? BLEND_DIV : r_pix;
    assign chk_start = (r_state == S_LGO);

    rcls_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    rcls_fit_chk u_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (chk_start),
        .i_avg   (r_avg),
        .i_lim   (r_lim),
        .i_wgt   (r_wgt),
        .o_done  (chk_done),
        .o_fit   (chk_fit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_budget  <= BUDGET_RST;
            r_edge    <= EDGE_RST;
            r_avg     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BUDGET: r_budget <= i_cfg_data;
                    REG_EDGE:   r_edge   <= i_cfg_data[W_EDGE-1:0];
                    default: ;
                endcase
            end

            // in the output state a taken slot is refilled at once
            if (m_axis_tvalid && m_axis_tready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_fw    <= s_axis_tdata[W_EDGE-1:0];
                        r_fh    <= s_axis_tdata[2*W_EDGE-1:W_EDGE];
                        r_ft    <= s_axis_tdata[2*W_EDGE+W_TIME-1:2*W_EDGE];
                        r_ok    <= !s_axis_tuser
                                   && (s_axis_tdata[W_EDGE-1:0] != '0)
                                   && (s_axis_tdata[2*W_EDGE-1:W_EDGE] != '0)
                                   && (s_axis_tdata[2*W_EDGE+W_TIME-1:2*W_EDGE] != '0);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_pix   <= W_PIX'(r_fw) * W_PIX'(r_fh);
                    r_tk    <= W_TK'(r_ft) * W_TK'(NS_PER_US);
                    r_avg7  <= W_NUM'({r_avg, 3'b000}) - W_NUM'(r_avg);
                    r_lim   <= {lim_hi, 16'h0000};
                    r_lvl   <= '0;
                    r_taken <= 1'b0;
                    r_state <= r_ok ? S_SDIV_GO : S_LSQ;
                end
                S_SDIV_GO: begin
                    r_state <= S_SDIV;
                end
                S_SDIV: begin
                    if (div_done) begin
                        if (r_avg == '0) begin
                            // no estimate yet: the sample stands as it is
                            r_next  <= div_quot;
                            r_state <= S_UPD;
                        end else begin
                            r_s3    <= W_NUM'({div_quot[W_SAMPLE-1:0], 1'b0})
                                       + W_NUM'(div_quot[W_SAMPLE-1:0]);
                            r_state <= S_BDIV_GO;
                        end
                    end
                end
                S_BDIV_GO: begin
                    r_state <= S_BDIV;
                end
                S_BDIV: begin
                    if (div_done) begin
                        r_next  <= div_quot;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_avg   <= next_sat;
                    r_taken <= 1'b1;
                    r_state <= S_LSQ;
                end
                S_LSQ: begin
                    if (r_avg == '0) begin
                        r_lvl   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_wgt   <= {e_sq, 1'b0};
                        r_state <= S_LGO;
                    end
                end
                S_LGO: begin
                    r_state <= S_LWAIT;
                end
                S_LWAIT: begin
                    if (chk_done) begin
                        if (chk_fit || (r_lvl == LAST_LEVEL)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_lvl   <= r_lvl + 1'b1;
                            r_state <= S_LSQ;
                        end
                    end
                end
                S_OUT: begin
                    // wait for the output register to free up
                    if (!r_o_valid || m_axis_tready) begin
                        r_o_valid <= 1'b1;
                        r_o_taken <= r_taken;
                        r_o_cost  <= r_avg;
                        r_o_level <= r_lvl;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_taken;
    assign m_axis_tdata  = W_OUT'({r_o_level, r_o_cost});

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_o_level <= LAST_LEVEL))
        else $error("chosen level beyond the coarsest level");

    a_no_cost_level0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_o_cost == '0)) |-> (r_o_level == '0))
        else $error("level other than 0 with no estimate");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && !in_acc) |=> (r_state == S_IDLE))
        else $error("left idle without an accepted item");

    a_chk_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chk_done |-> (r_state == S_LWAIT))
        else $error("fit check finished outside the level walk");

endmodule

`default_nettype wire
